[rtl/simcc_keypoint_decode_unit_defines.svh]
// Assertion macros shared by the keypoint decoder's checker.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef SIMCC_KEYPOINT_DECODE_UNIT_DEFINES_SVH
`define SIMCC_KEYPOINT_DECODE_UNIT_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define SKD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property that also holds across reset, used for reset behavior itself.
`define SKD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/skd_pkg.sv]
// Shared types and constants of the SimCC keypoint decoder.
// Depends on nothing; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps

package skd_pkg;

    // Field widths.
    localparam int BIN_W      = 9;
    localparam int KP_W       = 5;
    localparam int SCORE_W    = 16;
    localparam int CONF_W     = 15;
    localparam int COORD_W    = 32;
    localparam int SCALE_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int K_W        = BIN_W + SCALE_W;
    localparam int PROD_W     = COORD_W + K_W + 1;
    localparam int ACC_W      = PROD_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_D     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_E     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_F     = 3'd6;

    // Register reset values: half a pixel per bin, identity matrix.
    localparam logic [SCALE_W-1:0]        RST_BIN_SCALE = 16'h8000;
    localparam logic signed [COORD_W-1:0] RST_ONE       = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] RST_ZERO      = 32'sh0000_0000;

    // Configuration register set.
    typedef struct packed {
        logic [SCALE_W-1:0]        bin_scale;
        logic signed [COORD_W-1:0] mat_a;
        logic signed [COORD_W-1:0] mat_b;
        logic signed [COORD_W-1:0] mat_c;
        logic signed [COORD_W-1:0] mat_d;
        logic signed [COORD_W-1:0] mat_e;
        logic signed [COORD_W-1:0] mat_f;
    } t_cfg;

    // One finished keypoint waiting for its coordinate transform.
    typedef struct packed {
        logic [KP_W-1:0]   kp_index;
        logic [BIN_W-1:0]  x_bin;
        logic [BIN_W-1:0]  y_bin;
        logic [CONF_W-1:0] conf;
        logic              done;
    } t_job;

    // Fill status of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/skd_bin_if.sv]
// Stream interface for incoming classifier bins.
// Depends on skd_pkg for field widths.
`timescale 1ns / 1ps

interface skd_bin_if;
    logic                              valid;
    logic                              ready;
    logic                              axis;
    logic signed [skd_pkg::SCORE_W-1:0] bin_score;
    logic                              row_end;

    modport source (output valid, output axis, output bin_score, output row_end,
                    input ready);
    modport sink   (input valid, input axis, input bin_score, input row_end,
                    output ready);
endinterface

[rtl/skd_kp_if.sv]
// Stream interface for decoded keypoints.
// Depends on skd_pkg for field widths.
`timescale 1ns / 1ps

interface skd_kp_if;
    logic                                valid;
    logic                                ready;
    logic [skd_pkg::KP_W-1:0]            keypoint_index;
    logic signed [skd_pkg::COORD_W-1:0]  pos_x;
    logic signed [skd_pkg::COORD_W-1:0]  pos_y;
    logic [skd_pkg::CONF_W-1:0]          confidence;
    logic                                person_done;

    modport source (output valid, output keypoint_index, output pos_x, output pos_y,
                    output confidence, output person_done, input ready);
    modport sink   (input valid, input keypoint_index, input pos_x, input pos_y,
                    input confidence, input person_done, output ready);
endinterface

[rtl/skd_front.sv]
// Front end: takes one bin per cycle while the job queue has room, tracks the row maxima
// and their first index, and pushes a finished keypoint job at the end of each y row. Uses skd_pkg.
`timescale 1ns / 1ps

module skd_front #(
    parameter int X_BINS        = 384,
    parameter int Y_BINS        = 512,
    parameter int NUM_KEYPOINTS = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    skd_bin_if.sink             i_bin,
    input  skd_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output skd_pkg::t_job       o_job
);

    localparam logic [skd_pkg::BIN_W-1:0] X_LIM   = skd_pkg::BIN_W'(X_BINS - 1);
    localparam logic [skd_pkg::BIN_W-1:0] Y_LIM   = skd_pkg::BIN_W'(Y_BINS - 1);
    localparam logic [skd_pkg::BIN_W-1:0] CNT_MAX = '1;
    localparam logic [skd_pkg::KP_W-1:0]  KP_LAST = skd_pkg::KP_W'(NUM_KEYPOINTS - 1);

    logic [skd_pkg::BIN_W-1:0]          r_bin_cnt, n_bin_cnt;
    logic signed [skd_pkg::SCORE_W-1:0] r_best_x, n_best_x;
    logic signed [skd_pkg::SCORE_W-1:0] r_best_y, n_best_y;
    logic [skd_pkg::BIN_W-1:0]          r_x_bin, n_x_bin;
    logic [skd_pkg::BIN_W-1:0]          r_y_bin, n_y_bin;
    logic [skd_pkg::KP_W-1:0]           r_kp_cnt, n_kp_cnt;

    logic                               w_take;
    logic                               w_first;
    logic [skd_pkg::BIN_W-1:0]          w_limit;
    logic [skd_pkg::BIN_W-1:0]          w_idx;
    logic signed [skd_pkg::SCORE_W-1:0] w_min;
    logic                               w_done;

    // Bins are held back only while the job queue has no room.
    assign i_bin.ready = !i_q_status.full;
    assign w_take      = i_bin.valid && i_bin.ready;

    // Bin index of this score, clamped to the last bin of its axis.
    assign w_first = (r_bin_cnt == '0);
    assign w_limit = i_bin.axis ? Y_LIM : X_LIM;
    assign w_idx   = (r_bin_cnt < w_limit) ? r_bin_cnt : w_limit;

    // Running maximum update and bin counter.
    always_comb begin
        n_best_x  = r_best_x;
        n_best_y  = r_best_y;
        n_x_bin   = r_x_bin;
        n_y_bin   = r_y_bin;
        n_bin_cnt = r_bin_cnt;
        if (w_take) begin
            if (i_bin.axis) begin
                if (w_first || (i_bin.bin_score > r_best_y)) begin
                    n_best_y = i_bin.bin_score;
                    n_y_bin  = w_idx;
                end
            end else begin
                if (w_first || (i_bin.bin_score > r_best_x)) begin
                    n_best_x = i_bin.bin_score;
                    n_x_bin  = w_idx;
                end
            end
            if (i_bin.row_end) begin
                n_bin_cnt = '0;
            end else if (r_bin_cnt != CNT_MAX) begin
                n_bin_cnt = r_bin_cnt + 1'b1;
            end
        end
    end

    // A y row end closes the keypoint; the job carries the updated maxima.
    assign o_push = w_take && i_bin.axis && i_bin.row_end;
    assign w_min  = (n_best_x < n_best_y) ? n_best_x : n_best_y;
    assign w_done = (r_kp_cnt == KP_LAST);

    always_comb begin
        o_job.kp_index = r_kp_cnt;
        o_job.x_bin    = n_x_bin;
        o_job.y_bin    = n_y_bin;
        o_job.conf     = w_min[skd_pkg::SCORE_W-1] ? '0 : w_min[skd_pkg::CONF_W-1:0];
        o_job.done     = w_done;
    end

    // Keypoint counter returns to zero after the last keypoint of a person.
    always_comb begin
        n_kp_cnt = r_kp_cnt;
        if (o_push) begin
            n_kp_cnt = w_done ? '0 : r_kp_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
            r_best_x  <= '0;
            r_best_y  <= '0;
            r_x_bin   <= '0;
            r_y_bin   <= '0;
            r_kp_cnt  <= '0;
        end else begin
            r_bin_cnt <= n_bin_cnt;
            r_best_x  <= n_best_x;
            r_best_y  <= n_best_y;
            r_x_bin   <= n_x_bin;
            r_y_bin   <= n_y_bin;
            r_kp_cnt  <= n_kp_cnt;
        end
    end

endmodule

[rtl/skd_queue.sv]
// Short job queue between the bin front end and the transform back end.
// Depends on skd_pkg for the job type and the status struct.
`timescale 1ns / 1ps

module skd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  skd_pkg::t_job       i_job,
    input  logic                i_pop,
    output skd_pkg::t_job       o_head,
    output skd_pkg::t_q_status  o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    skd_pkg::t_job     r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_FULL);
    assign o_status.empty  = (r_count == '0);

    // Entry storage; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/skd_back.sv]
// Back end: scales both bin indices and runs the inverse affine transform
// on one shared multiplier, then holds the keypoint in an output register.
// Depends on skd_pkg and skd_kp_if.
`timescale 1ns / 1ps

module skd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skd_pkg::t_cfg       i_cfg,
    input  skd_pkg::t_job       i_head,
    input  skd_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    skd_kp_if.source            o_kp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [2:0] STEP_LAST = 3'd4;
    localparam int         SHR_W     = skd_pkg::ACC_W - skd_pkg::FRAC_W;

    // Floor division by 2^16 then saturation to the signed 32-bit range.
    function automatic logic signed [skd_pkg::COORD_W-1:0] f_round_sat(
        input logic signed [skd_pkg::ACC_W-1:0] acc
    );
        logic [SHR_W-1:0]                    shr;
        logic [SHR_W-skd_pkg::COORD_W:0]     upper;
        logic signed [skd_pkg::COORD_W-1:0]  res;
        shr   = acc[skd_pkg::ACC_W-1:skd_pkg::FRAC_W];
        upper = shr[SHR_W-1:skd_pkg::COORD_W-1];
        if ((&upper) || !(|upper)) begin
            res = shr[skd_pkg::COORD_W-1:0];
        end else if (shr[SHR_W-1]) begin
            res = {1'b1, {(skd_pkg::COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(skd_pkg::COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic [1:0]                          r_state, n_state;
    logic [2:0]                          r_step;
    skd_pkg::t_job                       r_job;
    logic [skd_pkg::K_W-1:0]             r_kx;
    logic [skd_pkg::K_W-1:0]             r_ky;
    logic signed [skd_pkg::PROD_W-1:0]   r_prod;
    logic signed [skd_pkg::ACC_W-1:0]    r_acc_x;
    logic signed [skd_pkg::ACC_W-1:0]    r_acc_y;

    logic                                r_out_valid;
    logic [skd_pkg::KP_W-1:0]            r_out_kp;
    logic signed [skd_pkg::COORD_W-1:0]  r_out_x;
    logic signed [skd_pkg::COORD_W-1:0]  r_out_y;
    logic [skd_pkg::CONF_W-1:0]          r_out_conf;
    logic                                r_out_done;

    logic                                w_emit;
    logic signed [skd_pkg::COORD_W-1:0]  w_coef;
    logic signed [skd_pkg::K_W:0]        w_k;
    logic signed [skd_pkg::PROD_W-1:0]   w_prod;

    // Sequencer control.
    assign o_pop  = (r_state == ST_IDLE) && !i_q_status.empty;
    assign w_emit = (r_state == ST_EMIT) && (!r_out_valid || o_kp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (o_pop) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_MUL;
            ST_MUL:   if (r_step == STEP_LAST) n_state = ST_EMIT;
            ST_EMIT:  if (w_emit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Coefficient and scaled bin for the current multiply step.
    always_comb begin
        case (r_step[1:0])
            2'd0:    begin w_coef = i_cfg.mat_a; w_k = $signed({1'b0, r_kx}); end
            2'd1:    begin w_coef = i_cfg.mat_b; w_k = $signed({1'b0, r_ky}); end
            2'd2:    begin w_coef = i_cfg.mat_d; w_k = $signed({1'b0, r_kx}); end
            default: begin w_coef = i_cfg.mat_e; w_k = $signed({1'b0, r_ky}); end
        endcase
    end

    assign w_prod = skd_pkg::PROD_W'(w_coef) * skd_pkg::PROD_W'(w_k);

    // Datapath: job capture, bin scaling, then multiply and accumulate.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_state == ST_SCALE) begin
            r_kx    <= skd_pkg::K_W'(r_job.x_bin) * skd_pkg::K_W'(i_cfg.bin_scale);
            r_ky    <= skd_pkg::K_W'(r_job.y_bin) * skd_pkg::K_W'(i_cfg.bin_scale);
            // Offset times 2^16 plus half an LSB for rounding to nearest.
            r_acc_x <= $signed({{(skd_pkg::ACC_W - skd_pkg::COORD_W - skd_pkg::FRAC_W)
                                  {i_cfg.mat_c[skd_pkg::COORD_W-1]}},
                                i_cfg.mat_c, 16'h8000});
            r_acc_y <= $signed({{(skd_pkg::ACC_W - skd_pkg::COORD_W - skd_pkg::FRAC_W)
                                  {i_cfg.mat_f[skd_pkg::COORD_W-1]}},
                                i_cfg.mat_f, 16'h8000});
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
            case (r_step) inside
                3'd1, 3'd2: r_acc_x <= r_acc_x + skd_pkg::ACC_W'(r_prod);
                3'd3, 3'd4: r_acc_y <= r_acc_y + skd_pkg::ACC_W'(r_prod);
                default:    ;
            endcase
        end
    end

    // Output register decouples the transform from the downstream stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_kp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kp   <= r_job.kp_index;
            r_out_x    <= f_round_sat(r_acc_x);
            r_out_y    <= f_round_sat(r_acc_y);
            r_out_conf <= r_job.conf;
            r_out_done <= r_job.done;
        end
    end

    assign o_kp.valid          = r_out_valid;
    assign o_kp.keypoint_index = r_out_kp;
    assign o_kp.pos_x          = r_out_x;
    assign o_kp.pos_y          = r_out_y;
    assign o_kp.confidence     = r_out_conf;
    assign o_kp.person_done    = r_out_done;

endmodule

[rtl/simcc_keypoint_decode_unit.sv]
// A y row end job passes the queue, then the SCALE, MUL and EMIT states, then the output register.
// Throughput: one bin per cycle while the job queue has room; the transform works on one keypoint
// at a time on one shared 32x26 multiplier, and a job queue of QUEUE_DEPTH entries absorbs short rows.
// Reset (synchronous, active low) restores the default scale and identity matrix,
// clears counters and maxima, and empties the queue and the output register.
// Top level; depends on skd_pkg, skd_bin_if, skd_kp_if, skd_front, skd_queue, skd_back.
`timescale 1ns / 1ps

module simcc_keypoint_decode_unit #(
    parameter int X_BINS        = 384,
    parameter int Y_BINS        = 512,
    parameter int NUM_KEYPOINTS = 17,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [skd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [skd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    skd_bin_if.sink                            i_bin,
    skd_kp_if.source                           o_kp
);

    skd_pkg::t_cfg       r_cfg;
    skd_pkg::t_q_status  w_q_status;
    skd_pkg::t_job       w_push_job;
    skd_pkg::t_job       w_head;
    logic                w_push;
    logic                w_pop;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_scale <= skd_pkg::RST_BIN_SCALE;
            r_cfg.mat_a     <= skd_pkg::RST_ONE;
            r_cfg.mat_b     <= skd_pkg::RST_ZERO;
            r_cfg.mat_c     <= skd_pkg::RST_ZERO;
            r_cfg.mat_d     <= skd_pkg::RST_ZERO;
            r_cfg.mat_e     <= skd_pkg::RST_ONE;
            r_cfg.mat_f     <= skd_pkg::RST_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skd_pkg::CFG_BIN_SCALE: r_cfg.bin_scale <= i_cfg_data[skd_pkg::SCALE_W-1:0];
                skd_pkg::CFG_MAT_A:     r_cfg.mat_a     <= $signed(i_cfg_data);
                skd_pkg::CFG_MAT_B:     r_cfg.mat_b     <= $signed(i_cfg_data);
                skd_pkg::CFG_MAT_C:     r_cfg.mat_c     <= $signed(i_cfg_data);
                skd_pkg::CFG_MAT_D:     r_cfg.mat_d     <= $signed(i_cfg_data);
                skd_pkg::CFG_MAT_E:     r_cfg.mat_e     <= $signed(i_cfg_data);
                skd_pkg::CFG_MAT_F:     r_cfg.mat_f     <= $signed(i_cfg_data);
                default:                ;
            endcase
        end
    end

    // Bin tracking front end.
    skd_front #(
        .X_BINS        (X_BINS),
        .Y_BINS        (Y_BINS),
        .NUM_KEYPOINTS (NUM_KEYPOINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bin      (i_bin),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // Job queue between the two halves.
    skd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Coordinate transform back end.
    skd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_kp       (o_kp)
    );

endmodule

[rtl/skd_checker.sv]
// Port-level assertions for the keypoint decoder and their bind to the top level.
// Depends on simcc_keypoint_decode_unit_defines.svh and skd_pkg.
`timescale 1ns / 1ps
`include "simcc_keypoint_decode_unit_defines.svh"

module skd_checker #(
    parameter int NUM_KEYPOINTS = 17
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [skd_pkg::KP_W-1:0]   i_out_kp_index,
    input logic                       i_out_person_done
);

    // A keypoint offered downstream stays offered until it is taken.
    `SKD_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "keypoint dropped")

    // Reset empties the output register.
    `SKD_ASSERT_RST(a_out_reset, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Reset empties the queue, so bins are taken right after it.
    `SKD_ASSERT_RST(a_in_reset, !i_rst_n |=> i_in_ready, "input not ready after reset")

    // The person closes only on its last keypoint.
    `SKD_ASSERT(a_done_last, i_out_valid && i_out_person_done |-> i_out_kp_index == skd_pkg::KP_W'(NUM_KEYPOINTS - 1), "person_done on wrong keypoint")

endmodule

bind simcc_keypoint_decode_unit skd_checker #(
    .NUM_KEYPOINTS (NUM_KEYPOINTS)
) u_skd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_bin.ready),
    .i_out_valid       (o_kp.valid),
    .i_out_ready       (o_kp.ready),
    .i_out_kp_index    (o_kp.keypoint_index),
    .i_out_person_done (o_kp.person_done)
);
